// File: rtl/mandelbrot_escape_time_core_macros.svh
// assertion macros for the mandelbrot escape-time core checker
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBET_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MBET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mbet_pkg.sv
// shared types, constants and helpers of the mandelbrot escape-time core
package mbet_pkg;

   localparam int unsigned Q_W       = 32;
   localparam int unsigned FRAC_BITS = 28;
   localparam int unsigned PROD_W    = 2 * Q_W;
   localparam int unsigned SUM_W     = 48;
   localparam int unsigned COORD_W   = 10;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned STEP_W    = 31;
   localparam int unsigned CSR_IDX_W = 3;
   // |z|^2 >= 4 in Q8.56 means any bit at or above this position is set
   localparam int unsigned ESC_BIT   = 2 * FRAC_BITS + 2;

   typedef logic signed [Q_W-1:0]    q_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RE_CORNER = 3'd0,
      CSR_IM_CORNER = 3'd1,
      CSR_RE_STEP   = 3'd2,
      CSR_IM_STEP   = 3'd3,
      CSR_MAX_ITER  = 3'd4
   } csr_index_type;

   localparam q_type                RE_CORNER_RST = 32'shE000_0000;
   localparam q_type                IM_CORNER_RST = 32'sh1800_0000;
   localparam logic [STEP_W-1:0]    STEP_RST      = 31'd786432;
   localparam logic [COUNT_W-1:0]   MAX_ITER_RST  = 8'd100;

   // clamp a widened sum to the signed Q4.28 range
   function automatic q_type sat_q(input sum_type v);
      q_type r;
      if ((&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1])) begin
         r = v[Q_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(Q_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: rtl/mbet_mul.sv
// shared registered signed 32x32 multiplier of the escape-time core
module mbet_mul (
   input  logic             clock,
   input  mbet_pkg::q_type  op_a,
   input  mbet_pkg::q_type  op_b,
   output mbet_pkg::prod_type prod
);
   import mbet_pkg::*;

   prod_type prod_in;
   prod_type prod_ff;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: rtl/mandelbrot_escape_time_core.sv
// top level of the mandelbrot escape-time core: sequencer, datapath and registers
//
//   channel   ports                                        handshake
//   --------  -------------------------------------------  ---------------------------
//   request   req_col, req_row                             start high, busy low
//   response  rsp_out_col, rsp_out_row, rsp_iter_count     rsp_valid, one cycle only
//   csr       csr_index, csr_data                          csr_valid and csr_ready
//
// one pixel runs ST_MUL_RE, ST_MUL_IM and ST_ADD_IM to form c, then per iteration ST_SQ_X,
// ST_SQ_Y, ST_MUL_XY (escape test) and ST_UPDATE, and strobes its result in ST_DONE
// busy drops when ST_DONE returns to idle, so the core takes no new pixel until then
// the single shared multiplier sets this order: three products per iteration plus an update
// reset is synchronous and returns the sequencer to idle and csr words to defaults
// the response side cannot stall; csr_ready is always high
module mandelbrot_escape_time_core #(
   parameter int IMAGE_SIZE = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mbet_pkg::COORD_W-1:0]      req_col,
   input  logic [mbet_pkg::COORD_W-1:0]      req_row,
   output logic                              rsp_valid,
   output logic [mbet_pkg::COORD_W-1:0]      rsp_out_col,
   output logic [mbet_pkg::COORD_W-1:0]      rsp_out_row,
   output logic [mbet_pkg::COUNT_W-1:0]      rsp_iter_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mbet_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbet_pkg::Q_W-1:0]          csr_data
);
   import mbet_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_MUL_RE = 9'b0_0000_0010,
      ST_MUL_IM = 9'b0_0000_0100,
      ST_ADD_IM = 9'b0_0000_1000,
      ST_SQ_X   = 9'b0_0001_0000,
      ST_SQ_Y   = 9'b0_0010_0000,
      ST_MUL_XY = 9'b0_0100_0000,
      ST_UPDATE = 9'b0_1000_0000,
      ST_DONE   = 9'b1_0000_0000
   } state_type;

   // fold a coordinate into the image by constant shifted subtractions
   function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      r = v;
      for (int k = COORD_W - 1; k >= 0; k--) begin
         if ((longint'(IMAGE_SIZE) << k) < (longint'(1) << COORD_W)) begin
            if (longint'(r) >= (longint'(IMAGE_SIZE) << k)) begin
               r = r - COORD_W'(longint'(IMAGE_SIZE) << k);
            end
         end
      end
      return r;
   endfunction

   // control state
   state_type            state_ff, state_in;
   q_type                re_corner_ff, re_corner_in;
   q_type                im_corner_ff, im_corner_in;
   logic [STEP_W-1:0]    re_step_ff, re_step_in;
   logic [STEP_W-1:0]    im_step_ff, im_step_in;
   logic [COUNT_W-1:0]   max_iter_ff, max_iter_in;

   // payload
   logic [COORD_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   q_type                c_re_ff, c_re_in;
   q_type                c_im_ff, c_im_in;
   q_type                x_ff, x_in;
   q_type                y_ff, y_in;
   prod_type             xx_ff, xx_in;
   prod_type             diff_ff, diff_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   // shared multiplier
   q_type                mul_a;
   q_type                mul_b;
   prod_type             prod;
   logic [PROD_W-1:0]    mag;
   logic                 escape;

   mbet_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // operand select for the multiplier, result lands in the next cycle
   always_comb begin
      case (state_ff)
         ST_MUL_RE: begin
            mul_a = q_type'({{(Q_W-COORD_W){1'b0}}, col_ff});
            mul_b = q_type'({1'b0, re_step_ff});
         end
         ST_MUL_IM: begin
            mul_a = q_type'({{(Q_W-COORD_W){1'b0}}, row_ff});
            mul_b = q_type'({1'b0, im_step_ff});
         end
         ST_SQ_X: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         ST_SQ_Y: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
      endcase
   end

   // in the cross-product cycle prod holds y*y and xx_ff holds x*x, both non-negative
   assign mag    = unsigned'(xx_ff) + unsigned'(prod);
   assign escape = |mag[PROD_W-1:ESC_BIT];

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      re_corner_in = re_corner_ff;
      im_corner_in = im_corner_ff;
      re_step_in   = re_step_ff;
      im_step_in   = im_step_ff;
      max_iter_in  = max_iter_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xx_in        = xx_ff;
      diff_in      = diff_ff;
      count_in     = count_ff;

      // csr words; writing them only while idle is up to the user, the core does not enforce it
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RE_CORNER: re_corner_in = csr_data;
            CSR_IM_CORNER: im_corner_in = csr_data;
            CSR_RE_STEP:   re_step_in   = csr_data[STEP_W-1:0];
            CSR_IM_STEP:   im_step_in   = csr_data[STEP_W-1:0];
            CSR_MAX_ITER:  max_iter_in  = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               col_in   = wrap_coord(req_col);
               row_in   = wrap_coord(req_row);
               x_in     = '0;
               y_in     = '0;
               count_in = '0;
               state_in = ST_MUL_RE;
            end
         end
         ST_MUL_RE: begin
            state_in = ST_MUL_IM;
         end
         ST_MUL_IM: begin
            // prod holds col * re_step
            c_re_in  = sat_q(sum_type'(re_corner_ff) + sum_type'(prod));
            state_in = ST_ADD_IM;
         end
         ST_ADD_IM: begin
            // prod holds row * im_step
            c_im_in = sat_q(sum_type'(im_corner_ff) - sum_type'(prod));
            if (max_iter_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            xx_in    = prod;
            state_in = ST_MUL_XY;
         end
         ST_MUL_XY: begin
            diff_in = xx_ff - prod;
            if (escape) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // prod holds x*y; shifting by one less doubles it
            x_in     = sat_q(sum_type'(diff_ff >>> FRAC_BITS) + sum_type'(c_re_ff));
            y_in     = sat_q(sum_type'(prod >>> (FRAC_BITS - 1)) + sum_type'(c_im_ff));
            count_in = count_ff + 1'b1;
            if ((count_ff + 1'b1) >= max_iter_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQ_X;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         re_corner_ff <= RE_CORNER_RST;
         im_corner_ff <= IM_CORNER_RST;
         re_step_ff   <= STEP_RST;
         im_step_ff   <= STEP_RST;
         max_iter_ff  <= MAX_ITER_RST;
      end else begin
         state_ff     <= state_in;
         re_corner_ff <= re_corner_in;
         im_corner_ff <= im_corner_in;
         re_step_ff   <= re_step_in;
         im_step_ff   <= im_step_in;
         max_iter_ff  <= max_iter_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      c_re_ff  <= c_re_in;
      c_im_ff  <= c_im_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      xx_ff    <= xx_in;
      diff_ff  <= diff_in;
      count_ff <= count_in;
   end

   // outputs straight from registers
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_out_col    = col_ff;
   assign rsp_out_row    = row_ff;
   assign rsp_iter_count = count_ff;
   assign csr_ready      = 1'b1;

endmodule

// File: rtl/mbet_chk.sv
// port-level checker of the mandelbrot escape-time core and its bind
`include "mandelbrot_escape_time_core_macros.svh"

module mbet_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);

   // a result only shows while the core holds the pixel
   `MBET_ASSERT_IMPLY(a_rsp_while_busy, clock, reset, rsp_valid, busy, "result strobe while idle")

   // one strobe per pixel, then the core frees up
   `MBET_ASSERT_NEXT(a_rsp_then_idle, clock, reset, rsp_valid, !rsp_valid && !busy, "no idle")

   // an accepted word starts work and cannot answer at once
   `MBET_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "no busy")

   // busy only drops after the result word went out
   `MBET_ASSERT_NEXT(a_busy_holds, clock, reset, busy && !rsp_valid, busy, "busy dropped early")

   // csr words are always taken while idle
   `MBET_ASSERT_IMPLY(a_csr_ready_idle, clock, reset, !busy, csr_ready, "csr not ready while idle")

endmodule

bind mandelbrot_escape_time_core mbet_chk u_mbet_chk (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the mandelbrot escape-time core, with an escape-count scoreboard
module tb;
   import mbet_pkg::*;

   // geometry and run length
   localparam int IMAGE_SIZE    = 1024;
   localparam int RANDOM_ITEMS  = 1150;
   // longest pixel: limit reached after 255 iterations, up to the point where busy drops
   localparam int TAIL_CYCLES   = 5 + 4 * 255;
   localparam int CSR_INDEX_TOP = (1 << CSR_IDX_W) - 1;

   // saturation bounds and escape threshold of the fixed-point iteration
   localparam longint      Q_MAX        = 64'sd2147483647;
   localparam longint      Q_MIN        = -64'sd2147483648;
   localparam logic [63:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);

   // one result word: pixel position and its escape count
   typedef struct {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COUNT_W-1:0] count;
   } pixel_word_type;

   // keeps a shadow of the csr words and the escape counts still owed by the core
   class escape_scoreboard;
      q_type               re_corner;
      q_type               im_corner;
      logic [STEP_W-1:0]   re_step;
      logic [STEP_W-1:0]   im_step;
      logic [COUNT_W-1:0]  max_iter;
      pixel_word_type      owed_q[$];
      int                  errors;

      function new();
         errors    = 0;
         re_corner = RE_CORNER_RST;
         im_corner = IM_CORNER_RST;
         re_step   = STEP_RST;
         im_step   = STEP_RST;
         max_iter  = MAX_ITER_RST;
      endfunction

      // csr write as the core sees it; indexes past max_iter are dropped
      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
         case (idx)
            CSR_RE_CORNER: re_corner = data;
            CSR_IM_CORNER: im_corner = data;
            CSR_RE_STEP:   re_step   = data[STEP_W-1:0];
            CSR_IM_STEP:   im_step   = data[STEP_W-1:0];
            CSR_MAX_ITER:  max_iter  = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_q(input longint v);
         if (v > Q_MAX) begin
            return Q_MAX;
         end else if (v < Q_MIN) begin
            return Q_MIN;
         end
         return v;
      endfunction

      // z = z^2 + c from zero, exact products, floor shifts, saturated iterates
      function pixel_word_type escape_time(input logic [COORD_W-1:0] col_in,
                                           input logic [COORD_W-1:0] row_in);
         pixel_word_type w;
         longint         c_re, c_im, x, y, xx, yy, nx, ny;
         logic [63:0]    mag2;
         int             n;
         w.col = COORD_W'(int'(col_in) % IMAGE_SIZE);
         w.row = COORD_W'(int'(row_in) % IMAGE_SIZE);
         c_re  = clamp_q(longint'(re_corner) + longint'(w.col) * longint'(re_step));
         c_im  = clamp_q(longint'(im_corner) - longint'(w.row) * longint'(im_step));
         x = 0;
         y = 0;
         n = 0;
         while (n < int'(max_iter)) begin
            xx   = x * x;
            yy   = y * y;
            // both squares are non-negative, so the raw bits are the unsigned sum
            mag2 = xx + yy;
            if (mag2 >= ESCAPE_LIMIT) break;
            nx = clamp_q(((xx - yy) >>> FRAC_BITS) + c_re);
            ny = clamp_q(((x * y) >>> (FRAC_BITS - 1)) + c_im);
            x  = nx;
            y  = ny;
            n++;
         end
         w.count = COUNT_W'(n);
         return w;
      endfunction

      function void note_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
         owed_q.push_back(escape_time(col, row));
      endfunction

      function int owed();
         return owed_q.size();
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                        input logic [COUNT_W-1:0] count);
         pixel_word_type want;
         if (owed_q.size() == 0) begin
            report_mismatch($sformatf("result col %0d row %0d count %0d with no pixel owed",
                                      col, row, count));
            return;
         end
         want = owed_q.pop_front();
         if (col !== want.col)
            report_mismatch($sformatf("out_col got %0d want %0d", col, want.col));
         if (row !== want.row)
            report_mismatch($sformatf("out_row got %0d want %0d", row, want.row));
         if (count !== want.count)
            report_mismatch($sformatf("iter_count got %0d want %0d (col %0d row %0d)",
                                      count, want.count, want.col, want.row));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [COORD_W-1:0]    req_col;
   logic [COORD_W-1:0]    req_row;
   logic                  rsp_valid;
   logic [COORD_W-1:0]    rsp_out_col;
   logic [COORD_W-1:0]    rsp_out_row;
   logic [COUNT_W-1:0]    rsp_iter_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [Q_W-1:0]        csr_data;

   escape_scoreboard sb = new();

   mandelbrot_escape_time_core #(
      .IMAGE_SIZE(IMAGE_SIZE)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_iter_count (rsp_iter_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // 10 ns clock, low first so the first rising edge comes at 5 ns
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // everything is sampled at the rising edge, before the core's updates land
   always @(posedge clock) begin
      if (!reset) begin
         // a csr word updates the shadow registers used for later pixels
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         // a pixel word is taken when start is high and the core is free
         if (start && !busy) sb.note_pixel(req_col, req_row);
         // a response word lives for one cycle only, so it is checked right here
         if (rsp_valid) sb.check_result(rsp_out_col, rsp_out_row, rsp_iter_count);
      end
   end

   // offer one pixel word from a falling edge; returns at the falling edge after it is taken
   // start stays high so a following word can go out with no gap
   task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      logic taken;
      start   = 1'b1;
      req_col = col;
      req_row = row;
      do begin
         @(posedge clock);
         taken = !busy;
      end while (!taken);
      @(negedge clock);
   endtask

   // one csr word over the write channel
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
      logic taken;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do begin
         @(posedge clock);
         taken = csr_ready;
      end while (!taken);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_config(input logic [Q_W-1:0] rc, input logic [Q_W-1:0] ic,
                               input logic [Q_W-1:0] rs, input logic [Q_W-1:0] is,
                               input logic [Q_W-1:0] mi);
      write_csr(CSR_RE_CORNER, rc);
      write_csr(CSR_IM_CORNER, ic);
      write_csr(CSR_RE_STEP, rs);
      write_csr(CSR_IM_STEP, is);
      write_csr(CSR_MAX_ITER, mi);
   endtask

   // stop offering pixels and wait for every owed word and for busy to drop
   task automatic finish_phase();
      start = 1'b0;
      do @(posedge clock); while (sb.owed() != 0 || busy);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [Q_W-1:0] rc, ic, rs, is, mi;
      int             sent, phase_len, n, burst, k, gap, pick;
      bit             steady;

      // every input known from time zero
      start     = 1'b0;
      req_col   = '0;
      req_row   = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // defaults after reset: image corners, the center (a point inside the set) and an outside point
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd100, 10'd300);
      finish_phase();

      // extreme corners and steps: c saturates, step words carry a stray top bit
      apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_01FF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1, 10'd0);
      send_pixel(10'd0, 10'd1);
      finish_phase();

      // iteration limit of zero, plus writes to unused indexes that must change nothing
      apply_config(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF00);
      for (k = int'(CSR_MAX_ITER) + 1; k <= CSR_INDEX_TOP; k++)
         write_csr(CSR_IDX_W'(k), $urandom);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd77, 10'd900);
      finish_phase();

      // c = -2 escapes exactly on the |z|^2 = 4 boundary
      apply_config(32'hE000_0000, 32'h0, 32'h0, 32'h0, 32'h0000_00FF);
      send_pixel(10'd0, 10'd0);
      finish_phase();
      // c = 0.25 and c = 0 never escape, full 255 iterations
      write_csr(CSR_RE_CORNER, 32'h0400_0000);
      send_pixel(10'd3, 10'd3);
      finish_phase();
      write_csr(CSR_RE_CORNER, 32'h0);
      send_pixel(10'd9, 10'd9);
      finish_phase();

      // single iteration over the default view
      apply_config(RE_CORNER_RST, IM_CORNER_RST, Q_W'(STEP_RST), Q_W'(STEP_RST), 32'h1);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd512, 10'd512);
      finish_phase();

      // random phases: new csr words while idle, then bursts of random pixels
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            // a view around the set, fine enough to give a spread of counts
            rc = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
            ic = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
            rs = $urandom_range(0, 32'h0020_0000);
            is = $urandom_range(0, 32'h0020_0000);
         end else begin
            // anything at all, mostly saturating coordinates
            rc = $urandom;
            ic = $urandom;
            rs = $urandom;
            is = $urandom;
         end
         // small limits keep the run short; a few phases go to zero or the top
         pick = $urandom_range(0, 19);
         mi   = $urandom & 32'hFFFF_FF00;
         if (pick == 0) begin
            mi = mi;
         end else if (pick == 1) begin
            mi = mi | 32'hFF;
         end else if (pick < 5) begin
            mi = mi | $urandom_range(33, 254);
         end else begin
            mi = mi | $urandom_range(1, 32);
         end
         apply_config(rc, ic, rs, is, mi);
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_IDX_W'($urandom_range(int'(CSR_MAX_ITER) + 1, CSR_INDEX_TOP)),
                      $urandom);

         phase_len = $urandom_range(20, 80);
         steady    = ($urandom_range(0, 3) == 0);
         n         = 0;
         while (n < phase_len) begin
            burst = $urandom_range(1, 16);
            for (k = 0; k < burst && n < phase_len; k++) begin
               send_pixel(COORD_W'($urandom), COORD_W'($urandom));
               n++;
            end
            // gaps land on whatever iteration the core is in at the time
            gap = 0;
            if (!steady && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 12);
            if (gap > 0) begin
               start = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         sent += n;
         finish_phase();
      end

      // let any stray strobe show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog well past the slowest correct run
   initial begin : watchdog
      #60_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
